[rtl/interp_step_setup_defines.svh]
// ----------------------------------------------------------------------------
// Interpolation step setup: assertion macros
// Shared property forms for the checker of the setup block.
// ----------------------------------------------------------------------------
`ifndef INTERP_STEP_SETUP_DEFINES_SVH
`define INTERP_STEP_SETUP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define ISS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iss_pkg.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: package
// Widths, lane indexes and the word types that travel down the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iss_pkg;

    localparam int COMP_W         = 16;
    localparam int FRAC_SHIFT     = 16;
    localparam int DIVIDEND_W     = COMP_W + FRAC_SHIFT;
    localparam int STEPS_W        = 15;
    localparam int LANES          = 4;
    localparam int BITS_PER_STAGE = 4;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_W = 3;

    localparam logic [FRAC_SHIFT-1:0] HALF_BIAS = 16'h8000;

    typedef struct packed {
        logic                  neg;
        logic [STEPS_W-1:0]    rem;
        logic [DIVIDEND_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        logic                           err;
        logic [STEPS_W-1:0]             divisor;
        logic [LANES-1:0][COMP_W-1:0]   ref_lo;
        t_lane [LANES-1:0]              lane;
    } t_work;

    typedef struct packed {
        logic                             err;
        logic [LANES-1:0][DIVIDEND_W-1:0] delta;
        logic [LANES-1:0][DIVIDEND_W-1:0] seed;
    } t_result;

endpackage

[rtl/iss_prep.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: input stage
// Forms the shifted differences, their signs and magnitudes, and registers
// the word that enters the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iss_prep import iss_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [STEPS_W-1:0]           i_steps,
    input  logic [LANES-1:0][COMP_W-1:0] i_target,
    input  logic [LANES-1:0][COMP_W-1:0] i_ref,
    output logic                         o_valid,
    output t_work                        o_work
);

    logic [LANES-1:0][COMP_W-1:0]     diff;
    logic [LANES-1:0][DIVIDEND_W-1:0] num;
    t_work                            n_work;
    t_work                            r_work;
    logic                             r_valid;

    always_comb begin
        n_work         = '0;
        n_work.err     = (i_steps == '0);
        n_work.divisor = i_steps;
        for (int l = 0; l < LANES; l++) begin
            diff[l] = i_target[l] - i_ref[l];
            num[l]  = {diff[l], {FRAC_SHIFT{1'b0}}};
            n_work.ref_lo[l]   = i_ref[l];
            n_work.lane[l].neg = diff[l][COMP_W-1];
            n_work.lane[l].rem = '0;
            n_work.lane[l].quo = diff[l][COMP_W-1] ? ('0 - num[l]) : num[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

[rtl/iss_div_stage.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: divider stage
// Retires P_BITS quotient bits of every lane by shift and trial subtract,
// then registers the partial remainders and quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iss_div_stage import iss_pkg::*; #(
    parameter int P_BITS = BITS_PER_STAGE
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_valid,
    output t_work o_work
);

    t_work n_work;
    t_work r_work;
    logic  r_valid;

    always_comb begin
        logic [STEPS_W:0] trial;
        logic [STEPS_W:0] sub;
        logic             take;
        n_work = i_work;
        for (int l = 0; l < LANES; l++) begin
            for (int b = 0; b < P_BITS; b++) begin
                trial = {n_work.lane[l].rem, n_work.lane[l].quo[DIVIDEND_W-1]};
                sub   = trial - {1'b0, i_work.divisor};
                take  = (trial >= {1'b0, i_work.divisor});
                n_work.lane[l].rem = take ? sub[STEPS_W-1:0] : trial[STEPS_W-1:0];
                n_work.lane[l].quo = {n_work.lane[l].quo[DIVIDEND_W-2:0], take};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

[rtl/iss_out.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: output stage
// Restores quotient signs, forces zero increments on a zero step count,
// builds the seeds, and holds the result word in an output and skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iss_out import iss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_work   i_work,
    input  logic    i_stall,
    output logic    o_hold,
    output logic    o_valid,
    output t_result o_result
);

    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;
    logic    out_free;

    always_comb begin
        n_result.err = i_work.err;
        for (int l = 0; l < LANES; l++) begin
            if (i_work.err) begin
                n_result.delta[l] = '0;
            end else if (i_work.lane[l].neg) begin
                n_result.delta[l] = '0 - i_work.lane[l].quo;
            end else begin
                n_result.delta[l] = i_work.lane[l].quo;
            end
            n_result.seed[l] = {i_work.ref_lo[l], HALF_BIAS};
        end
    end

    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_valid;
            end
        end else if (i_valid && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : n_result;
        end
        if (!out_free && !r_skid_vld) begin
            r_skid <= n_result;
        end
    end

    assign o_hold   = r_skid_vld;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

[rtl/interp_step_setup.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: top level
// From accept to result a word passes the input register, the divider stage
// chain and the output register. Throughput: one word per cycle while o_stall
// is low; sync reset clears all valid bits, no payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interp_step_setup import iss_pkg::*; #(
    parameter int P_BITS_PER_STAGE = BITS_PER_STAGE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [STEPS_W-1:0]           i_steps,
    input  logic signed [COMP_W-1:0]     i_target_x,
    input  logic signed [COMP_W-1:0]     i_target_y,
    input  logic signed [COMP_W-1:0]     i_target_z,
    input  logic signed [DIVIDEND_W-1:0] i_target_w,
    input  logic signed [COMP_W-1:0]     i_ref_x,
    input  logic signed [COMP_W-1:0]     i_ref_y,
    input  logic signed [COMP_W-1:0]     i_ref_z,
    input  logic signed [DIVIDEND_W-1:0] i_ref_w,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DIVIDEND_W-1:0] o_delta_x,
    output logic signed [DIVIDEND_W-1:0] o_delta_y,
    output logic signed [DIVIDEND_W-1:0] o_delta_z,
    output logic signed [DIVIDEND_W-1:0] o_delta_w,
    output logic signed [DIVIDEND_W-1:0] o_seed_x,
    output logic signed [DIVIDEND_W-1:0] o_seed_y,
    output logic signed [DIVIDEND_W-1:0] o_seed_z,
    output logic signed [DIVIDEND_W-1:0] o_seed_w,
    output logic                         o_div_error
);

    localparam int DIV_STAGES = DIVIDEND_W / P_BITS_PER_STAGE;

    logic [LANES-1:0][COMP_W-1:0] target;
    logic [LANES-1:0][COMP_W-1:0] ref_in;
    logic                         hold;
    logic                         en;
    logic [DIV_STAGES:0]          stage_vld;
    t_work                        stage_work [DIV_STAGES+1];
    t_result                      result;

    assign target[LANE_X] = i_target_x;
    assign target[LANE_Y] = i_target_y;
    assign target[LANE_Z] = i_target_z;
    assign target[LANE_W] = i_target_w[COMP_W-1:0];
    assign ref_in[LANE_X] = i_ref_x;
    assign ref_in[LANE_Y] = i_ref_y;
    assign ref_in[LANE_Z] = i_ref_z;
    assign ref_in[LANE_W] = i_ref_w[COMP_W-1:0];

    assign en      = !hold;
    assign o_stall = hold;

    iss_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_steps  (i_steps),
        .i_target (target),
        .i_ref    (ref_in),
        .o_valid  (stage_vld[0]),
        .o_work   (stage_work[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        iss_div_stage #(
            .P_BITS (P_BITS_PER_STAGE)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stage_vld[s]),
            .i_work  (stage_work[s]),
            .o_valid (stage_vld[s+1]),
            .o_work  (stage_work[s+1])
        );
    end

    iss_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_vld[DIV_STAGES]),
        .i_work   (stage_work[DIV_STAGES]),
        .i_stall  (i_stall),
        .o_hold   (hold),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_delta_x   = result.delta[LANE_X];
    assign o_delta_y   = result.delta[LANE_Y];
    assign o_delta_z   = result.delta[LANE_Z];
    assign o_delta_w   = result.delta[LANE_W];
    assign o_seed_x    = result.seed[LANE_X];
    assign o_seed_y    = result.seed[LANE_Y];
    assign o_seed_z    = result.seed[LANE_Z];
    assign o_seed_w    = result.seed[LANE_W];
    assign o_div_error = result.err;

endmodule

[rtl/iss_checker.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: port checker
// Watches the top-level ports for output holding, skid behavior, zero
// increments on error and the seed bias.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "interp_step_setup_defines.svh"

module iss_checker import iss_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [DIVIDEND_W-1:0] o_delta_x,
    input logic signed [DIVIDEND_W-1:0] o_delta_y,
    input logic signed [DIVIDEND_W-1:0] o_delta_z,
    input logic signed [DIVIDEND_W-1:0] o_delta_w,
    input logic signed [DIVIDEND_W-1:0] o_seed_x,
    input logic signed [DIVIDEND_W-1:0] o_seed_w,
    input logic                         o_div_error
);

    `ISS_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_delta_x) && $stable(o_seed_w) && $stable(o_div_error),
        "stalled output word changed")
    `ISS_ASSERT_NOW(a_stall_has_word, o_stall, o_valid,
        "input stalled with no output word pending")
    `ISS_ASSERT_NOW(a_err_zero, o_valid && o_div_error,
        o_delta_x == '0 && o_delta_y == '0 && o_delta_z == '0 && o_delta_w == '0,
        "nonzero increment with zero step count")
    `ISS_ASSERT_NOW(a_seed_bias, o_valid,
        o_seed_x[FRAC_SHIFT-1:0] == HALF_BIAS && o_seed_w[FRAC_SHIFT-1:0] == HALF_BIAS,
        "seed lost its half bias")

endmodule

bind interp_step_setup iss_checker u_iss_checker (.*);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Interpolation step setup: testbench
// Drives setup words through the valid/stall input channel. A scoreboard
// computes the 16.16 increments, seeds and zero-step flag of every accepted
// word and checks the result words in order. It runs directed corner words,
// then random words under three idling mixes on the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import iss_pkg::*;

    localparam int  RANDOM_PER_PHASE = 200;
    localparam int  TAIL_CYCLES      = 20;
    localparam time RUN_LIMIT        = 2_000_000;

    typedef struct packed {
        logic [STEPS_W-1:0]               steps;
        logic [LANES-1:0][DIVIDEND_W-1:0] target;
        logic [LANES-1:0][DIVIDEND_W-1:0] origin;
    } t_setup_word;

    class setup_scoreboard;
        t_result expected_q[$];
        int      mismatches;
        int      checked;
        int      words;
        int      zero_steps;
        string   lane_tag[LANES] = '{"x", "y", "z", "w"};

        function t_result predict_setup(t_setup_word w);
            t_result         r;
            logic [31:0]     num;
            longint          q;
            r.err = (w.steps == '0);
            for (int l = 0; l < LANES; l++) begin
                num = (w.target[l] - w.origin[l]) << FRAC_SHIFT;
                if (r.err) begin
                    r.delta[l] = '0;
                end else begin
                    q = longint'($signed(num)) / longint'(w.steps);
                    r.delta[l] = q[31:0];
                end
                r.seed[l] = (w.origin[l] << FRAC_SHIFT) | 32'(HALF_BIAS);
            end
            return r;
        endfunction

        function void note_word(t_setup_word w);
            words++;
            if (w.steps == '0) zero_steps++;
            expected_q.push_back(predict_setup(w));
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %h, got %h", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result word arrived with nothing expected");
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            for (int l = 0; l < LANES; l++) begin
                compare_field($sformatf("delta_%s", lane_tag[l]), exp_r.delta[l], got.delta[l]);
                compare_field($sformatf("seed_%s", lane_tag[l]), exp_r.seed[l], got.seed[l]);
            end
            compare_field("div_error", 32'(exp_r.err), 32'(got.err));
        endfunction
    endclass

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    logic [STEPS_W-1:0]           i_steps    = '0;
    logic signed [COMP_W-1:0]     i_target_x = '0;
    logic signed [COMP_W-1:0]     i_target_y = '0;
    logic signed [COMP_W-1:0]     i_target_z = '0;
    logic signed [DIVIDEND_W-1:0] i_target_w = '0;
    logic signed [COMP_W-1:0]     i_ref_x    = '0;
    logic signed [COMP_W-1:0]     i_ref_y    = '0;
    logic signed [COMP_W-1:0]     i_ref_z    = '0;
    logic signed [DIVIDEND_W-1:0] i_ref_w    = '0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    logic signed [DIVIDEND_W-1:0] o_delta_x;
    logic signed [DIVIDEND_W-1:0] o_delta_y;
    logic signed [DIVIDEND_W-1:0] o_delta_z;
    logic signed [DIVIDEND_W-1:0] o_delta_w;
    logic signed [DIVIDEND_W-1:0] o_seed_x;
    logic signed [DIVIDEND_W-1:0] o_seed_y;
    logic signed [DIVIDEND_W-1:0] o_seed_z;
    logic signed [DIVIDEND_W-1:0] o_seed_w;
    logic                         o_div_error;

    int send_idle_pct  = 8;
    int recv_stall_pct = 62;

    setup_scoreboard sb = new();

    interp_step_setup DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_steps     (i_steps),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .i_target_z  (i_target_z),
        .i_target_w  (i_target_w),
        .i_ref_x     (i_ref_x),
        .i_ref_y     (i_ref_y),
        .i_ref_z     (i_ref_z),
        .i_ref_w     (i_ref_w),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_delta_x   (o_delta_x),
        .o_delta_y   (o_delta_y),
        .o_delta_z   (o_delta_z),
        .o_delta_w   (o_delta_w),
        .o_seed_x    (o_seed_x),
        .o_seed_y    (o_seed_y),
        .o_seed_z    (o_seed_z),
        .o_seed_w    (o_seed_w),
        .o_div_error (o_div_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_setup_word w;
        t_result     got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                w.steps          = i_steps;
                w.target[LANE_X] = {{16{i_target_x[15]}}, i_target_x};
                w.target[LANE_Y] = {{16{i_target_y[15]}}, i_target_y};
                w.target[LANE_Z] = {{16{i_target_z[15]}}, i_target_z};
                w.target[LANE_W] = i_target_w;
                w.origin[LANE_X] = {{16{i_ref_x[15]}}, i_ref_x};
                w.origin[LANE_Y] = {{16{i_ref_y[15]}}, i_ref_y};
                w.origin[LANE_Z] = {{16{i_ref_z[15]}}, i_ref_z};
                w.origin[LANE_W] = i_ref_w;
                sb.note_word(w);
            end
            if (o_valid && !i_stall) begin
                got.err          = o_div_error;
                got.delta[LANE_X] = o_delta_x;
                got.delta[LANE_Y] = o_delta_y;
                got.delta[LANE_Z] = o_delta_z;
                got.delta[LANE_W] = o_delta_w;
                got.seed[LANE_X]  = o_seed_x;
                got.seed[LANE_Y]  = o_seed_y;
                got.seed[LANE_Z]  = o_seed_z;
                got.seed[LANE_W]  = o_seed_w;
                sb.check_result(got);
            end
        end
    end

    function automatic logic [31:0] rand_value(int width);
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = 32'(1) << (width - 1);
            1: v = (32'(1) << (width - 1)) - 1;
            2: v = '0;
            3: v = '1;
            4: v = 32'($urandom_range(40)) - 32'd20;
            default: v = $urandom;
        endcase
        if (width == COMP_W) v = {{16{v[15]}}, v[15:0]};
        return v;
    endfunction

    function automatic t_setup_word random_word();
        t_setup_word w;
        case ($urandom_range(19))
            0: w.steps = '0;
            1: w.steps = STEPS_W'(1);
            2: w.steps = '1;
            3, 4, 5: w.steps = STEPS_W'($urandom_range(16, 1));
            default: w.steps = STEPS_W'($urandom);
        endcase
        for (int l = 0; l < LANES; l++) begin
            w.target[l] = rand_value(l == LANE_W ? DIVIDEND_W : COMP_W);
            w.origin[l] = rand_value(l == LANE_W ? DIVIDEND_W : COMP_W);
        end
        return w;
    endfunction

    function automatic t_setup_word make_word(int steps, int tx, int ty, int tz, int tw,
                                              int rx, int ry, int rz, int rw);
        t_setup_word w;
        w.steps          = STEPS_W'(steps);
        w.target[LANE_X] = 32'(tx);
        w.target[LANE_Y] = 32'(ty);
        w.target[LANE_Z] = 32'(tz);
        w.target[LANE_W] = 32'(tw);
        w.origin[LANE_X] = 32'(rx);
        w.origin[LANE_Y] = 32'(ry);
        w.origin[LANE_Z] = 32'(rz);
        w.origin[LANE_W] = 32'(rw);
        return w;
    endfunction

    task automatic send_word(input t_setup_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_steps    <= w.steps;
        i_target_x <= w.target[LANE_X][15:0];
        i_target_y <= w.target[LANE_Y][15:0];
        i_target_z <= w.target[LANE_Z][15:0];
        i_target_w <= w.target[LANE_W];
        i_ref_x    <= w.origin[LANE_X][15:0];
        i_ref_y    <= w.origin[LANE_Y][15:0];
        i_ref_z    <= w.origin[LANE_Z][15:0];
        i_ref_w    <= w.origin[LANE_W];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // hold off the sender until every expected result word is back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_word(random_word());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(make_word(0, 100, -100, 32767, 1000, 0, 0, -32768, -1000));
        send_word(make_word(0, -32768, 32767, 0, 32'h7FFFFFFF, 32767, -32768, 0, 32'h80000000));
        send_word(make_word(1, 32767, -32768, 1, 32'h7FFFFFFF, -32768, 32767, -1,
                            32'h80000000));
        send_word(make_word(1, -32768, 32767, -1, 32'h80000000, 32767, -32768, 1,
                            32'h7FFFFFFF));
        send_word(make_word(32767, 32767, -32768, 0, 32'h7FFFFFFF, -32768, 32767, 0,
                            32'h80000000));
        send_word(make_word(32767, -32768, 32767, 5, 32'h80000000, 32767, -32768, 5,
                            32'h7FFFFFFF));
        send_word(make_word(3, 10, -10, 7, -7, 0, 0, 0, 0));
        send_word(make_word(7, -1, 1, 0, 32'hFFFF, 0, 0, 0, 32'h10000));
        send_word(make_word(2, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(32767, -1, -1, -1, -1, -1, -1, -1, -1));
        send_word(make_word(16384, 0, 0, 0, 0, 32767, -32768, 1, 32'h12345678));
        send_word(make_word(5, 1, -1, 2, 3, 0, 0, 0, 0));
        send_word(make_word(32766, 32767, 32767, -32768, 32'h55555555, -32768, -32768,
                            32767, 32'hAAAAAAAA));
        send_random(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct  = 62;
        recv_stall_pct = 8;
        send_random(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(RANDOM_PER_PHASE);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d setup words (%0d with zero steps) under three idling mixes;",
                 sb.words, sb.zero_steps);
        $display("checked %0d result words, %0d field mismatches.", sb.checked,
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Run limit reached with %0d result words outstanding", sb.expected_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
